FILE: src/fp32_to_int8_symmetric_quantizer_macros.svh
// Assertion macros for the fp32 to int8 quantizer checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FP32_TO_INT8_SYMMETRIC_QUANTIZER_MACROS_SVH
`define FP32_TO_INT8_SYMMETRIC_QUANTIZER_MACROS_SVH

// Checked on every edge outside reset.
`define F2I8_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define F2I8_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/f2i8_pkg.sv
// Shared types, constants and helper functions of the fp32 to int8 quantizer.
// No dependencies; the quantizer modules and the testbench import this package.
`timescale 1ns / 1ps
package f2i8_pkg;

  localparam int MANT_W    = 24;
  localparam int REM_W     = MANT_W + 1;
  localparam int QUO_W     = MANT_W + 2;
  localparam int DIV_CELLS = QUO_W;
  localparam int EXP_W     = 11;
  localparam int RND_EXP_W = 6;
  localparam int SUM_W     = 56;
  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;
  localparam logic signed [7:0] QMAX = 8'sd127;
  localparam logic signed [7:0] QMIN = -8'sd127;

  typedef enum logic [1:0] {
    CLS_NORM,
    CLS_ZERO,
    CLS_SAT
  } cls_t;

  typedef struct packed {
    logic                    sign;
    cls_t                    cls;
    logic signed [EXP_W-1:0] expo;
    logic [MANT_W-1:0]       divisor;
    logic [REM_W-1:0]        rem;
    logic [QUO_W-1:0]        quo;
    logic                    last;
  } div_t;

  typedef struct packed {
    logic                        sign;
    cls_t                        cls;
    logic signed [RND_EXP_W-1:0] expo;
    logic [MANT_W-1:0]           mant;
    logic                        last;
  } rnd_t;

  function automatic logic [4:0] lzc24(input logic [MANT_W-1:0] m);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 0; i < MANT_W; i++) begin
      if (m[i]) begin
        n = 5'(MANT_W - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

FILE: src/f2i8_if.sv
// Stream interfaces of the fp32 to int8 quantizer: sample items in, byte items out.
// No dependencies.
`timescale 1ns / 1ps
interface f2i8_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample;
  logic        last;
  modport source (output valid, sample, last, input ready);
  modport sink (input valid, sample, last, output ready);
endinterface

interface f2i8_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] quantized;
  logic              last_out;
  modport source (output valid, quantized, last_out, input ready);
  modport sink (input valid, quantized, last_out, output ready);
endinterface

FILE: src/fp32_to_int8_symmetric_quantizer.sv
// Symmetric int8 quantizer: divides each fp32 sample by the scale register,
// rounds half away from zero and clamps to -127..127.
// Depends on f2i8_pkg, f2i8_if, f2i8_unpack, f2i8_div_cell, f2i8_round, f2i8_sum.
//
// samples carries one fp32 bit pattern and a last flag per item; results
// carries the signed byte and the copied last flag, one item per sample,
// in order. scale_we with scale_wdata writes the divisor (reset value 1.0);
// write it only while the block is empty.
// The item passes 29 register stages: one unpack stage, 26 division cells
// that each resolve one quotient bit, one rounding stage and one output
// stage. Throughput is one item per cycle while the receiver takes results.
// Every stage holds its own item and moves when the stage after it is free,
// so a stalled receiver fills the chain from the output backward and
// bubbles close up; samples.ready drops only when every stage is full.
// Synchronous reset empties the chain and restores the scale.
`timescale 1ns / 1ps
module fp32_to_int8_symmetric_quantizer import f2i8_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        scale_we,
  input  logic [31:0] scale_wdata,
  f2i8_in_if.sink     samples,
  f2i8_out_if.source  results
);

  logic [31:0] scale;
  div_t        chain_d   [0:DIV_CELLS];
  logic        chain_v   [0:DIV_CELLS];
  logic        chain_rdy [0:DIV_CELLS];
  rnd_t        rnd_d;
  logic        rnd_v, rnd_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= SCALE_RESET;
    end else if (scale_we) begin
      scale <= scale_wdata;
    end
  end

  f2i8_unpack u_unpack (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .scale    (scale),
    .d_out    (chain_d[0]),
    .v_out    (chain_v[0]),
    .ready_dn (chain_rdy[0])
  );

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    f2i8_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .d_in     (chain_d[i]),
      .v_in     (chain_v[i]),
      .ready_up (chain_rdy[i]),
      .d_out    (chain_d[i+1]),
      .v_out    (chain_v[i+1]),
      .ready_dn (chain_rdy[i+1])
    );
  end

  f2i8_round u_round (
    .clk      (clk),
    .rst      (rst),
    .d_in     (chain_d[DIV_CELLS]),
    .v_in     (chain_v[DIV_CELLS]),
    .ready_up (chain_rdy[DIV_CELLS]),
    .r_out    (rnd_d),
    .v_out    (rnd_v),
    .ready_dn (rnd_rdy)
  );

  f2i8_sum u_sum (
    .clk      (clk),
    .rst      (rst),
    .r_in     (rnd_d),
    .v_in     (rnd_v),
    .ready_up (rnd_rdy),
    .results  (results)
  );

endmodule

FILE: src/f2i8_unpack.sv
// Input stage: classifies sample and scale, normalizes both significands.
// Depends on f2i8_pkg and f2i8_in_if.
`timescale 1ns / 1ps
module f2i8_unpack import f2i8_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  f2i8_in_if.sink        samples,
  input  logic [31:0]    scale,
  output div_t           d_out,
  output logic           v_out,
  input  logic           ready_dn
);

  logic       sa, sb, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0] ea, eb, ea_eff, eb_eff;
  logic [MANT_W-1:0] ma, mb;
  logic [4:0] la, lb;
  logic signed [EXP_W-1:0] exp_a, exp_b;
  div_t d_next;

  assign samples.ready = !v_out || ready_dn;

  always_comb begin
    sa = samples.sample[31];
    sb = scale[31];
    ea = samples.sample[30:23];
    eb = scale[30:23];
    a_nan  = (ea == 8'hFF) && (samples.sample[22:0] != 23'd0);
    b_nan  = (eb == 8'hFF) && (scale[22:0] != 23'd0);
    a_inf  = (ea == 8'hFF) && (samples.sample[22:0] == 23'd0);
    b_inf  = (eb == 8'hFF) && (scale[22:0] == 23'd0);
    a_zero = (ea == 8'h00) && (samples.sample[22:0] == 23'd0);
    b_zero = (eb == 8'h00) && (scale[22:0] == 23'd0);
    ma = {ea != 8'h00, samples.sample[22:0]};
    mb = {eb != 8'h00, scale[22:0]};
    la = lzc24(ma);
    lb = lzc24(mb);
    ea_eff = (ea == 8'h00) ? 8'd1 : ea;
    eb_eff = (eb == 8'h00) ? 8'd1 : eb;
    exp_a = $signed({3'b000, ea_eff}) - 11'sd127 - $signed({6'b000000, la});
    exp_b = $signed({3'b000, eb_eff}) - 11'sd127 - $signed({6'b000000, lb});
    d_next.sign    = sa ^ sb;
    d_next.expo    = exp_a - exp_b;
    d_next.divisor = mb << lb;
    d_next.rem     = {1'b0, ma << la};
    d_next.quo     = '0;
    d_next.last    = samples.last;
    if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
      d_next.cls  = CLS_SAT;
      d_next.sign = 1'b0;
    end else if (a_inf || b_zero) begin
      d_next.cls = CLS_SAT;
    end else if (a_zero || b_inf) begin
      d_next.cls = CLS_ZERO;
    end else begin
      d_next.cls = CLS_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (samples.ready) begin
      v_out <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.ready) begin
      d_out <= d_next;
    end
  end

endmodule

FILE: src/f2i8_div_cell.sv
// One restoring-division cell: produces one quotient bit and passes the item on.
// Depends on f2i8_pkg.
`timescale 1ns / 1ps
module f2i8_div_cell import f2i8_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  div_t d_in,
  input  logic v_in,
  output logic ready_up,
  output div_t d_out,
  output logic v_out,
  input  logic ready_dn
);

  logic             ge;
  logic [REM_W-1:0] diff;
  div_t             d_next;

  assign ready_up = !v_out || ready_dn;

  always_comb begin
    ge     = d_in.rem >= {1'b0, d_in.divisor};
    diff   = ge ? d_in.rem - {1'b0, d_in.divisor} : d_in.rem;
    d_next = d_in;
    d_next.rem = {diff[REM_W-2:0], 1'b0};
    d_next.quo = {d_in.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (ready_up) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      d_out <= d_next;
    end
  end

endmodule

FILE: src/f2i8_round.sv
// Rounds the quotient to single precision and sorts out tiny and huge values.
// Depends on f2i8_pkg.
`timescale 1ns / 1ps
module f2i8_round import f2i8_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  div_t d_in,
  input  logic v_in,
  output logic ready_up,
  output rnd_t r_out,
  output logic v_out,
  input  logic ready_dn
);

  logic [MANT_W-1:0]       mant;
  logic                    guard, sticky, rup;
  logic [MANT_W:0]         msum;
  logic signed [EXP_W-1:0] e_adj, e_fin;
  rnd_t                    r_next;

  assign ready_up = !v_out || ready_dn;

  always_comb begin
    if (d_in.quo[QUO_W-1]) begin
      mant   = d_in.quo[QUO_W-1:2];
      guard  = d_in.quo[1];
      sticky = d_in.quo[0] || (d_in.rem != '0);
      e_adj  = d_in.expo;
    end else begin
      mant   = d_in.quo[QUO_W-2:1];
      guard  = d_in.quo[0];
      sticky = d_in.rem != '0;
      e_adj  = d_in.expo - 11'sd1;
    end
    rup  = guard && (sticky || mant[0]);
    msum = {1'b0, mant} + {{MANT_W{1'b0}}, rup};
    if (msum[MANT_W]) begin
      r_next.mant = {1'b1, {(MANT_W-1){1'b0}}};
      e_fin       = e_adj + 11'sd1;
    end else begin
      r_next.mant = msum[MANT_W-1:0];
      e_fin       = e_adj;
    end
    r_next.sign = d_in.sign;
    r_next.last = d_in.last;
    r_next.expo = e_fin[RND_EXP_W-1:0];
    r_next.cls  = d_in.cls;
    if (d_in.cls == CLS_NORM) begin
      if (e_fin >= 11'sd7) begin
        r_next.cls = CLS_SAT;
      end else if (e_fin < -11'sd25) begin
        r_next.cls = CLS_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (ready_up) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      r_out <= r_next;
    end
  end

endmodule

FILE: src/f2i8_sum.sv
// Output stage: adds the signed half, rounds the sum, truncates and clamps.
// Depends on f2i8_pkg and f2i8_out_if.
`timescale 1ns / 1ps
module f2i8_sum import f2i8_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  rnd_t       r_in,
  input  logic       v_in,
  output logic       ready_up,
  f2i8_out_if.source results
);

  logic signed [6:0] sh_full;
  logic [4:0]        sh;
  logic [SUM_W-1:0]  s, t;
  logic [3:0]        k;
  logic              rb, stk, lsb, rup;
  logic [8:0]        mag;
  logic signed [7:0] q_next;

  assign ready_up = !results.valid || results.ready;

  always_comb begin
    sh_full = {r_in.expo[RND_EXP_W-1], r_in.expo} + 7'sd25;
    sh      = sh_full[4:0];
    s = ({{(SUM_W-MANT_W){1'b0}}, r_in.mant} << sh) + (SUM_W'(1) << 47);
    k = 4'd0;
    for (int j = 0; j < 9; j++) begin
      if (s[47+j]) begin
        k = 4'(j);
      end
    end
    rb  = s[23+k];
    lsb = s[24+k];
    stk = (s & ((SUM_W'(1) << (23 + k)) - SUM_W'(1))) != '0;
    rup = rb && (stk || lsb);
    t   = (s >> (24 + k)) + {{(SUM_W-1){1'b0}}, rup};
    mag = 9'(t >> (24 - k));
    unique case (r_in.cls)
      CLS_ZERO: q_next = 8'sd0;
      CLS_SAT:  q_next = r_in.sign ? QMIN : QMAX;
      CLS_NORM: begin
        if (mag >= 9'd127) begin
          q_next = r_in.sign ? QMIN : QMAX;
        end else begin
          q_next = r_in.sign ? -$signed(mag[7:0]) : $signed(mag[7:0]);
        end
      end
      default:  q_next = 8'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (ready_up) begin
      results.valid <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      results.quantized <= q_next;
      results.last_out  <= r_in.last;
    end
  end

endmodule

FILE: src/f2i8_checker.sv
// Port-level checks of the fp32 to int8 quantizer, bound to the top level.
// Depends on fp32_to_int8_symmetric_quantizer_macros.svh.
`timescale 1ns / 1ps
`include "fp32_to_int8_symmetric_quantizer_macros.svh"
module f2i8_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] quantized,
  input logic              last_out
);

  logic stall;

  assign stall = out_valid && !out_ready;

  `F2I8_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "Output valid right after reset.")
  `F2I8_ASSERT(a_range, out_valid |-> (quantized != -8'sd128), "Result outside -127..127.")
  `F2I8_ASSERT(a_hold_valid, stall |=> out_valid, "Stalled item dropped.")
  `F2I8_ASSERT(a_hold_data, stall |=> $stable({quantized, last_out}), "Stalled item changed.")
  `F2I8_ASSERT(a_ready_free, (!out_valid) |-> in_ready, "Input refused with an empty output.")

endmodule

bind fp32_to_int8_symmetric_quantizer f2i8_checker u_f2i8_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .quantized (results.quantized),
  .last_out  (results.last_out)
);

FILE: tb/sv/tb_fp32_to_int8_symmetric_quantizer.sv
// Self-checking testbench of the fp32 to int8 symmetric quantizer.
// It predicts every byte from the sample and scale with integer arithmetic.
// Depends on f2i8_pkg, f2i8_in_if, f2i8_out_if and the quantizer itself.
`timescale 1ns / 1ps
module tb_fp32_to_int8_symmetric_quantizer;
  import f2i8_pkg::*;

  typedef struct {
    logic [31:0] sample;
    logic        last;
  } sample_item_t;

  typedef struct {
    logic signed [7:0] quantized;
    logic              last;
  } byte_item_t;

  logic        clk;
  logic        rst;
  logic        scale_we;
  logic [31:0] scale_wdata;
  logic [31:0] cur_scale;
  logic        send_idle;
  logic        recv_idle;
  logic        long_hold_req;
  logic        long_hold_done;
  int          send_gap;
  int          recv_gap;
  int          hold_cnt;
  int          mismatches;
  int          failures;

  sample_item_t pending_samples[$];
  byte_item_t   expected_bytes[$];

  f2i8_in_if  samples_if();
  f2i8_out_if results_if();

  fp32_to_int8_symmetric_quantizer uut (
    .clk        (clk),
    .rst        (rst),
    .scale_we   (scale_we),
    .scale_wdata(scale_wdata),
    .samples    (samples_if),
    .results    (results_if)
  );

  // Exact single-precision divide and half add, then truncate and clamp.
  function automatic logic signed [7:0] quantize_expect(input logic [31:0] x,
                                                        input logic [31:0] d);
    logic        neg;
    logic        g;
    logic        st;
    logic [23:0] mx;
    logic [23:0] md;
    logic [23:0] qm;
    logic [49:0] num;
    logic [49:0] qi;
    logic [49:0] rem;
    logic [79:0] acc;
    logic [79:0] low;
    logic [79:0] hb;
    int          bx;
    int          bd;
    int          e;
    int          p;
    int          drop;
    int          iv;
    neg = x[31] ^ d[31];
    if ((x[30:23] == 8'hFF && x[22:0] != 0) || (d[30:23] == 8'hFF && d[22:0] != 0)) begin
      return QMAX;
    end
    if ((x[30:23] == 8'hFF && d[30:23] == 8'hFF) || (x[30:0] == 0 && d[30:0] == 0)) begin
      return QMAX;
    end
    if (x[30:23] == 8'hFF || d[30:0] == 0) begin
      return neg ? QMIN : QMAX;
    end
    if (d[30:23] == 8'hFF || x[30:0] == 0) begin
      return 8'sd0;
    end
    mx = (x[30:23] == 0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
    bx = (x[30:23] == 0) ? -149 : int'(x[30:23]) - 150;
    md = (d[30:23] == 0) ? {1'b0, d[22:0]} : {1'b1, d[22:0]};
    bd = (d[30:23] == 0) ? -149 : int'(d[30:23]) - 150;
    while (!mx[23]) begin
      mx = mx << 1;
      bx--;
    end
    while (!md[23]) begin
      md = md << 1;
      bd--;
    end
    num = {mx, 26'b0};
    qi  = num / md;
    rem = num % md;
    if (qi[26]) begin
      qm = qi[26:3];
      g  = qi[2];
      st = (qi[1:0] != 0) || (rem != 0);
      e  = bx - bd - 23;
    end else begin
      qm = qi[25:2];
      g  = qi[1];
      st = qi[0] || (rem != 0);
      e  = bx - bd - 24;
    end
    if (g && (st || qm[0])) begin
      qm = qm + 24'd1;
      if (qm == 0) begin
        qm = 24'h80_0000;
        e++;
      end
    end
    if (e + 23 >= 7) begin
      return neg ? QMIN : QMAX;
    end
    if (e + 24 < -30) begin
      return 8'sd0;
    end
    acc = 80'(qm) << (e + 60);
    acc = acc + (80'd1 << 59);
    p = 0;
    for (int i = 0; i < 80; i++) begin
      if (acc[i]) begin
        p = i;
      end
    end
    if (p > 23) begin
      drop = p - 23;
      low  = acc & ((80'd1 << drop) - 1);
      hb   = 80'd1 << (drop - 1);
      acc  = acc - low;
      if (low > hb || (low == hb && acc[drop])) begin
        acc = acc + (80'd1 << drop);
      end
    end
    iv = int'(acc >> 60);
    if (iv > 127) begin
      iv = 127;
    end
    return neg ? 8'(-iv) : 8'(iv);
  endfunction

  function automatic logic [31:0] pick_sample(input logic [31:0] d);
    logic [31:0] s;
    int          m;
    int          p;
    int          ex;
    s = $urandom;
    case ($urandom_range(0, 9))
      0, 1: begin
      end
      2: begin
        m = 2 * $urandom_range(0, 130) + 1;
        p = 0;
        for (int i = 0; i < 10; i++) begin
          if (m[i]) begin
            p = i;
          end
        end
        s = {s[31], 8'(p - 1 + 127), 23'(m << (23 - p))};
      end
      3: begin
        case ($urandom_range(0, 5))
          0: s = {s[31], 31'h7F80_0000};
          1: s = {s[31], 8'hFF, s[22:0] | 23'h1};
          2: s = {s[31], 31'h0};
          3: s = {s[31], 8'h00, s[22:0]};
          4: s = {s[31], 31'h7F7F_FFFF};
          default: s = {s[31], 31'h3F00_0000};
        endcase
      end
      default: begin
        if (d[30:23] == 0 || d[30:23] == 8'hFF) begin
          ex = $urandom_range(100, 150);
        end else begin
          ex = int'(d[30:23]) + $urandom_range(0, 17) - 9;
        end
        if (ex < 0) ex = 0;
        if (ex > 254) ex = 254;
        s[30:23] = 8'(ex);
      end
    endcase
    return s;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  // Sender: one item at a time from the pending queue, with a drawn gap after each while send_idle is set.
  always @(posedge clk) begin
    if (rst) begin
      samples_if.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (samples_if.valid && samples_if.ready) begin
        expected_bytes.push_back('{quantize_expect(samples_if.sample, cur_scale),
                                   samples_if.last});
      end
      if (!samples_if.valid || samples_if.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          samples_if.valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_item_t it;
          it = pending_samples.pop_front();
          samples_if.valid  <= 1'b1;
          samples_if.sample <= it.sample;
          samples_if.last   <= it.last;
          send_gap <= send_idle ? $urandom_range(0, 9) : 0;
        end else begin
          samples_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: may stall after each item while recv_idle is set, plus one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      recv_gap <= 0;
      hold_cnt <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_cnt <= 300;
      results_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      results_if.ready <= (hold_cnt == 1);
    end else if (results_if.valid && results_if.ready) begin
      int g;
      g = recv_idle ? $urandom_range(0, 9) : 0;
      recv_gap <= g;
      results_if.ready <= (g == 0);
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      results_if.ready <= (recv_gap == 1);
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      if (expected_bytes.size() == 0) begin
        failures++;
        $display("Unexpected item: quantized %0d last %0b",
                 results_if.quantized, results_if.last_out);
      end else begin
        byte_item_t ex;
        ex = expected_bytes.pop_front();
        if (ex.quantized !== results_if.quantized || ex.last !== results_if.last_out) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected %0d/%0b, got %0d/%0b", ex.quantized, ex.last,
                     results_if.quantized, results_if.last_out);
          end
        end
      end
    end
  end

  task automatic add_sample(input logic [31:0] s, input logic l);
    pending_samples.push_back('{s, l});
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || samples_if.valid || expected_bytes.size() > 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
  endtask

  task automatic write_scale(input logic [31:0] v);
    @(posedge clk);
    scale_we    <= 1'b1;
    scale_wdata <= v;
    cur_scale = v;
    @(posedge clk);
    scale_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] scales[12];
    scales = '{32'h3F80_0000, 32'h3C00_0000, 32'h3D4C_CCCD, 32'h447A_0000, 32'h0000_0000,
               32'h8000_0000, 32'h7FC0_0000, 32'h7F80_0000, 32'h0000_0001, 32'hFFFF_FFFF,
               32'h7F7F_FFFF, 32'hBE80_0000};
    mismatches = 0;
    failures = 0;
    cur_scale = SCALE_RESET;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    long_hold_req = 1'b0;
    scale_we = 1'b0;
    scale_wdata = 32'h0;
    samples_if.valid = 1'b0;
    samples_if.sample = 32'h0;
    samples_if.last = 1'b0;
    results_if.ready = 1'b0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset scale of one: zeros, halves, clamps and specials.
    add_sample(32'h0000_0000, 1'b0);
    add_sample(32'h8000_0000, 1'b1);
    add_sample(32'h3F00_0000, 1'b0);
    add_sample(32'hBF00_0000, 1'b0);
    add_sample(32'h3FC0_0000, 1'b0);
    add_sample(32'hBFC0_0000, 1'b0);
    add_sample(32'h4020_0000, 1'b0);
    add_sample(32'hC020_0000, 1'b0);
    add_sample(32'h42FD_0000, 1'b0);
    add_sample(32'hC2FD_0000, 1'b0);
    add_sample(32'h42FE_0000, 1'b0);
    add_sample(32'h4300_0000, 1'b0);
    add_sample(32'hC300_0000, 1'b1);
    add_sample(32'h7F80_0000, 1'b0);
    add_sample(32'hFF80_0000, 1'b0);
    add_sample(32'h7FC0_0000, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b0);
    add_sample(32'h0000_0001, 1'b0);
    add_sample(32'h8000_0001, 1'b0);
    add_sample(32'h7F7F_FFFF, 1'b0);
    add_sample(32'hFF7F_FFFF, 1'b0);
    add_sample(32'h3EFF_FFFF, 1'b0);
    add_sample(32'hBEFF_FFFF, 1'b0);
    add_sample(32'h3F00_0001, 1'b1);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      write_scale(scales[ph]);
      send_idle = (ph % 3 != 2);
      recv_idle = (ph % 4 != 3);
      if (ph == 1) begin
        send_idle = 1'b0;
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < 156; i++) begin
        add_sample(pick_sample(cur_scale), 1'($urandom_range(0, 1)));
      end
      drain();
    end

    failures = failures + mismatches + expected_bytes.size();
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/f2i8_pkg.sv
src/f2i8_if.sv
src/f2i8_unpack.sv
src/f2i8_div_cell.sv
src/f2i8_round.sv
src/f2i8_sum.sv
src/fp32_to_int8_symmetric_quantizer.sv
src/f2i8_checker.sv
tb/sv/tb_fp32_to_int8_symmetric_quantizer.sv
